FILE: rtl/bssc_pkg.sv
package bssc_pkg;

    localparam int LEVEL_W = 6;
    localparam int LV_W = LEVEL_W + 1;
    localparam int LEN_W = 11;
    localparam int CNT_W = 30;
    localparam int ROW_AW = LEVEL_W + 1;
    localparam int SUM_AW = 10;
    localparam int MAX_LEVELS = 64;
    localparam int SUM_DEPTH = 1024;
    localparam int ROW_DEPTH = 2 * MAX_LEVELS;

    localparam logic [LEN_W-1:0] MAX_LENGTH = 11'd1024;
    localparam logic [CNT_W:0] COUNT_MOD = 31'd1000000000;

    localparam logic REG_MAX_HEIGHT = 1'b0;
    localparam logic [LEVEL_W-1:0] MAX_HEIGHT_RST = 6'd1;

    typedef struct packed {
        logic restart;
        logic load_len;
        logic sweep_start;
        logic row_commit;
        logic sum_read;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_ext;
        logic sweep_done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= COUNT_MOD) begin
            s = s - COUNT_MOD;
        end
        return s[CNT_W-1:0];
    endfunction

endpackage

FILE: rtl/bssc_ctrl.sv
module bssc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cfg_wr,
    input  bssc_pkg::t_dp_sts i_sts,
    output bssc_pkg::t_dp_cmd o_cmd
);
    import bssc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SWEEP = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.restart = i_cfg_wr;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_len = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.need_ext) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state = S_SWEEP;
                end else begin
                    o_cmd.sum_read = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_SWEEP: begin
                if (i_sts.sweep_done) begin
                    o_cmd.row_commit = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/bssc_dp.sv
module bssc_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bssc_pkg::t_dp_cmd              i_cmd,
    output bssc_pkg::t_dp_sts              o_sts,
    input  logic [bssc_pkg::LEVEL_W-1:0]   i_max_height,
    input  logic [bssc_pkg::LEN_W-1:0]     i_query_length,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [bssc_pkg::CNT_W-1:0]     o_sequence_count
);
    import bssc_pkg::*;

    logic [CNT_W-1:0] r_row_mem [ROW_DEPTH];
    logic [CNT_W-1:0] r_sum_mem [SUM_DEPTH];

    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_rows;
    logic               r_bank;
    logic [LV_W-1:0]    r_k;
    logic               r_run;
    logic               r_s1_vld;
    logic [LV_W-1:0]    r_s1_k;
    logic               r_s1_flush;
    logic [CNT_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_a;
    logic [CNT_W-1:0]   r_b;
    logic               r_s2_vld;
    logic [LEVEL_W-1:0] r_s2_j;
    logic [CNT_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_c;
    logic               r_s3_vld;
    logic [LEVEL_W-1:0] r_s3_j;
    logic [CNT_W-1:0]   r_d;
    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_sum_rd;
    logic               r_sel_zero;
    logic               r_sel_first;
    logic               r_out_valid;
    logic [CNT_W-1:0]   r_out_data;

    logic [LV_W-1:0]    w_lv;
    logic [CNT_W-1:0]   w_x;
    logic [LEN_W-1:0]   w_len_sat;
    logic [LEN_W-1:0]   w_idx;
    logic [LV_W-1:0]    w_s1_jm;
    logic [CNT_W-1:0]   w_result;

    assign w_lv = {1'b0, i_max_height} + LV_W'(1);
    assign w_len_sat = (i_query_length > MAX_LENGTH) ? MAX_LENGTH : i_query_length;
    assign w_idx = r_len - LEN_W'(1);
    assign w_s1_jm = r_s1_k - LV_W'(1);

    // first row after restart is implicitly all ones; flush step has no right neighbor
    always_comb begin
        if (r_s1_flush) begin
            w_x = '0;
        end else if (r_rows == LEN_W'(1)) begin
            w_x = CNT_W'(1);
        end else begin
            w_x = r_rd;
        end
    end

    always_comb begin
        if (r_sel_zero) begin
            w_result = CNT_W'(1);
        end else if (r_sel_first) begin
            w_result = CNT_W'(w_lv);
        end else begin
            w_result = r_sum_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= LEN_W'(1);
            r_bank <= 1'b0;
            r_run <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.restart) begin
                r_rows <= LEN_W'(1);
                r_bank <= 1'b0;
            end else if (i_cmd.row_commit) begin
                r_rows <= r_rows + LEN_W'(1);
                r_bank <= ~r_bank;
            end
            if (i_cmd.sweep_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_k == w_lv)) begin
                r_run <= 1'b0;
            end
            r_s1_vld <= r_run;
            r_s2_vld <= r_s1_vld && (r_s1_k != '0);
            r_s3_vld <= r_s2_vld;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_len) begin
            r_len <= w_len_sat;
        end
        if (i_cmd.sweep_start) begin
            r_k <= '0;
        end else if (r_run) begin
            r_k <= r_k + LV_W'(1);
        end
        r_s1_k <= r_k;
        r_s1_flush <= (r_k == w_lv);
        if (i_cmd.sweep_start) begin
            r_a <= '0;
            r_b <= '0;
        end else if (r_s1_vld) begin
            r_a <= r_b;
            r_b <= w_x;
        end
        r_q <= mod_add(r_b, w_x);
        r_c <= r_a;
        r_s2_j <= w_s1_jm[LEVEL_W-1:0];
        r_d <= mod_add(r_q, r_c);
        r_s3_j <= r_s2_j;
        if (i_cmd.sweep_start) begin
            r_total <= '0;
        end else if (r_s3_vld) begin
            r_total <= mod_add(r_total, r_d);
        end
        if (i_cmd.sum_read) begin
            r_sel_zero <= (r_len == '0);
            r_sel_first <= (r_len == LEN_W'(1));
        end
        if (i_cmd.out_load) begin
            r_out_data <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            r_row_mem[{~r_bank, r_s3_j}] <= r_d;
        end
        if (r_run) begin
            r_rd <= r_row_mem[{r_bank, r_k[LEVEL_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_commit && (r_rows < MAX_LENGTH)) begin
            r_sum_mem[r_rows[SUM_AW-1:0]] <= r_total;
        end
        if (i_cmd.sum_read) begin
            r_sum_rd <= r_sum_mem[w_idx[SUM_AW-1:0]];
        end
    end

    assign o_sts.need_ext = (r_rows < r_len);
    assign o_sts.sweep_done = !r_run && !r_s1_vld && !r_s2_vld && !r_s3_vld;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_sequence_count = r_out_data;

endmodule

FILE: rtl/bounded_step_sequence_counter.sv
// A result is loaded once the row for the length is built; each new row the query
// needs takes one read-port sweep of H+1 levels first.
// One query at a time: a new query stalls until the previous result has been loaded;
// the first query of length 1024 or more after a restart builds the most rows.
// Reset (synchronous, active low): H = 1, one row built, no result pending.
// Writing max_height restarts the table with no clearing pass.
module bounded_step_sequence_counter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bssc_pkg::LEN_W-1:0]     i_query_length,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bssc_pkg::CNT_W-1:0]     o_sequence_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import bssc_pkg::*;

    logic [LEVEL_W-1:0] r_max_height;
    logic               w_cfg_wr;
    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;

    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_HEIGHT);
    assign prdata = (paddr[2] == REG_MAX_HEIGHT) ? {{(32-LEVEL_W){1'b0}}, r_max_height}
                                                 : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_height <= MAX_HEIGHT_RST;
        end else if (w_cfg_wr) begin
            r_max_height <= pwdata[LEVEL_W-1:0];
        end
    end

    bssc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cfg_wr   (w_cfg_wr),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bssc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_max_height     (r_max_height),
        .i_query_length   (i_query_length),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_sequence_count (o_sequence_count)
    );

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_sequence_count} < COUNT_MOD))
        else $error("result count not reduced");

    a_lookup_after_extend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sum_read |-> !w_sts.need_ext)
        else $error("sum table read before its row was built");

    a_sweep_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sweep_start |-> w_sts.sweep_done)
        else $error("row sweep started while previous sweep busy");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

FILE: dv/tb_bounded_step_sequence_counter.sv
`timescale 1ns / 100ps

module tb_bounded_step_sequence_counter;
    import bssc_pkg::*;

    localparam int CLK_HALF = 5;
    localparam int RST_CYCLES = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 250000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 130;
    localparam int DIR_N = 28;
    localparam logic [2:0] ADDR_MAX_HEIGHT = 3'(4 * REG_MAX_HEIGHT);
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef enum logic [1:0] {STEP_QUERY, STEP_WRITE, STEP_READ} t_step_op;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        t_step_op         op;
        logic [2:0]       addr;
        logic [31:0]      value;
        logic             pinned;
        logic [CNT_W-1:0] count;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [LEN_W-1:0] i_query_length = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [CNT_W-1:0] o_sequence_count;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    bounded_step_sequence_counter DUT (.*);

    always #CLK_HALF i_clk = ~i_clk;

    // walk-count predictor state
    logic [LEVEL_W-1:0] walk_height;
    logic [CNT_W-1:0]   walk_row [2][MAX_LEVELS];
    logic [CNT_W-1:0]   walk_sum [SUM_DEPTH];
    int unsigned        walk_rows;
    logic               walk_bank;

    logic [CNT_W-1:0] expected_counts [$];
    logic             pin_valid = 1'b0;
    logic [CNT_W-1:0] pin_count = '0;
    logic             hold_req = 1'b0;
    logic [CNT_W-1:0] want_count;
    t_dir_row         dir_tbl [DIR_N];

    int err_count = 0;
    int n_queries = 0;
    int n_counts = 0;
    int n_sat = 0;
    int n_zero = 0;
    int n_writes = 0;
    int idle_cycles = 0;

    function automatic int unsigned walk_levels();
        int unsigned lv;
        lv = walk_height + 1;
        return (lv > MAX_LEVELS) ? MAX_LEVELS : lv;
    endfunction

    function automatic void restart_walk_table();
        int unsigned lv;
        lv = walk_levels();
        for (int j = 0; j < MAX_LEVELS; j++) begin
            walk_row[0][j] = (j < lv) ? CNT_W'(1) : '0;
            walk_row[1][j] = '0;
        end
        for (int k = 0; k < SUM_DEPTH; k++) begin
            walk_sum[k] = '0;
        end
        walk_sum[0] = CNT_W'(lv % COUNT_MOD);
        walk_rows = 1;
        walk_bank = 1'b0;
    endfunction

    function automatic void grow_walk_row();
        int unsigned lv;
        longint unsigned acc;
        longint unsigned total;
        lv = walk_levels();
        total = 0;
        for (int unsigned j = 0; j < lv; j++) begin
            acc = walk_row[walk_bank][j];
            if (j > 0) begin
                acc += walk_row[walk_bank][j-1];
            end
            if (j + 1 < lv) begin
                acc += walk_row[walk_bank][j+1];
            end
            acc = acc % COUNT_MOD;
            walk_row[~walk_bank][j] = CNT_W'(acc);
            total = (total + acc) % COUNT_MOD;
        end
        if (walk_rows < MAX_LENGTH) begin
            walk_sum[walk_rows] = CNT_W'(total);
        end
        walk_rows++;
        walk_bank = ~walk_bank;
    endfunction

    function automatic logic [CNT_W-1:0] walk_count(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] eff;
        if (len == '0) begin
            return CNT_W'(1);
        end
        eff = (len > MAX_LENGTH) ? MAX_LENGTH : len;
        while (walk_rows < eff) begin
            grow_walk_row();
        end
        return walk_sum[eff - 1];
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return '0;
        end else if (r < 16) begin
            return LEN_W'($urandom_range(MAX_LENGTH + 1, 2047));
        end else if (r < 30) begin
            return LEN_W'($urandom_range(1, 16));
        end
        return LEN_W'($urandom_range(1, MAX_LENGTH));
    endfunction

    task automatic send_query(input logic [LEN_W-1:0] len, input logic pinned,
                              input logic [CNT_W-1:0] cnt);
        i_in_valid = 1'b1;
        i_query_length = len;
        pin_valid = pinned;
        pin_count = cnt;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MAX_HEIGHT) begin
            walk_height = data[LEVEL_W-1:0];
            restart_walk_table();
            n_writes++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(32-LEVEL_W){1'b0}}, walk_height}) begin
            $error("max_height readback: expected %0d, got %0d", walk_height, prdata);
            err_count++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_counts++;
                if (expected_counts.size() == 0) begin
                    $error("sequence_count: unexpected result, expected none, got %0d",
                           o_sequence_count);
                    err_count++;
                end else begin
                    want_count = expected_counts.pop_front();
                    if (o_sequence_count !== want_count) begin
                        $error("sequence_count: expected %0d, got %0d",
                               want_count, o_sequence_count);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want_count = walk_count(i_query_length);
                expected_counts.push_back(pin_valid ? pin_count : want_count);
                n_queries++;
                if (i_query_length > MAX_LENGTH) n_sat++;
                if (i_query_length == '0) n_zero++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("** bounded_step_sequence_counter: FAILED **");
                $finish;
            end
        end
    end

    // result-side backpressure
    initial begin : rx_stall
        t_rx_mode mode;
        int left;
        int period;
        int duty;
        int cyc;
        mode = RX_FREE;
        left = 0;
        period = 2;
        duty = 1;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    left = $urandom_range(32, 256);
                    period = $urandom_range(2, 9);
                    duty = $urandom_range(1, period - 1);
                end
                left--;
                cyc++;
                case (mode)
                    RX_FREE: i_out_stall = 1'b0;
                    RX_LIGHT: i_out_stall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = ((cyc % period) < duty);
                endcase
            end
        end
    end

    initial begin : stimulus
        int sent;
        int burst;
        logic [LEVEL_W-1:0] h;
        logic [LEVEL_W-1:0] corner_h [4];

        corner_h = '{6'd1, 6'd63, 6'd0, 6'd62};
        dir_tbl = '{
            '{STEP_QUERY, 3'd0, 32'd1, 1'b1, 30'd2},
            '{STEP_QUERY, 3'd0, 32'd2, 1'b1, 30'd4},
            '{STEP_QUERY, 3'd0, 32'd0, 1'b1, 30'd1},
            '{STEP_QUERY, 3'd0, 32'd3, 1'b1, 30'd8},
            '{STEP_QUERY, 3'd0, 32'd30, 1'b1, 30'd73741824},
            '{STEP_QUERY, 3'd0, 32'd1024, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd2047, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd1025, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd1, 1'b1, 30'd2},
            '{STEP_WRITE, ADDR_MAX_HEIGHT, 32'd0, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd1, 1'b1, 30'd1},
            '{STEP_QUERY, 3'd0, 32'd2047, 1'b1, 30'd1},
            '{STEP_QUERY, 3'd0, 32'd1024, 1'b1, 30'd1},
            '{STEP_QUERY, 3'd0, 32'd0, 1'b1, 30'd1},
            '{STEP_WRITE, ADDR_MAX_HEIGHT, 32'd63, 1'b0, 30'd0},
            '{STEP_READ, ADDR_MAX_HEIGHT, 32'd0, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd1, 1'b1, 30'd64},
            '{STEP_QUERY, 3'd0, 32'd2, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd1536, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd5, 1'b0, 30'd0},
            '{STEP_WRITE, ADDR_UNUSED, 32'd5, 1'b0, 30'd0},
            '{STEP_READ, ADDR_MAX_HEIGHT, 32'd0, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd1, 1'b1, 30'd64},
            '{STEP_QUERY, 3'd0, 32'd682, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd1365, 1'b0, 30'd0},
            '{STEP_WRITE, ADDR_MAX_HEIGHT, 32'hFFFF_FFC2, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd7, 1'b0, 30'd0},
            '{STEP_QUERY, 3'd0, 32'd1024, 1'b0, 30'd0}
        };

        walk_height = MAX_HEIGHT_RST;
        restart_walk_table();
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_N; r++) begin
            case (dir_tbl[r].op)
                STEP_QUERY: begin
                    send_query(dir_tbl[r].value[LEN_W-1:0], dir_tbl[r].pinned,
                               dir_tbl[r].count);
                end
                STEP_WRITE: begin
                    wait_drained();
                    apb_write(dir_tbl[r].addr, dir_tbl[r].value);
                end
                default: begin
                    wait_drained();
                    apb_read_check(dir_tbl[r].addr);
                end
            endcase
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            h = (p < 4) ? corner_h[p] : LEVEL_W'($urandom_range(0, 63));
            apb_write(ADDR_MAX_HEIGHT, ($urandom() & ~32'h3F) | {26'd0, h});
            apb_read_check(ADDR_MAX_HEIGHT);
            if (p == 0) begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
                    send_query(random_length(), 1'b0, '0);
                    sent++;
                end
                if ($urandom_range(0, 3) != 0) begin
                    idle_sender($urandom_range(1, 12));
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("%0d queries (%0d saturated, %0d zero-length), %0d counts checked,",
                 n_queries, n_sat, n_zero, n_counts);
        $display("%0d max_height settings incl. 0 and 63, with stalls and a long hold-off",
                 n_writes);
        if (err_count == 0) begin
            $display("** bounded_step_sequence_counter: PASSED **");
        end else begin
            $display("** bounded_step_sequence_counter: FAILED **");
        end
        $finish;
    end

endmodule
